/* src/mtg_pkg.sv */
`timescale 1ns / 1ps

package mtg_pkg;

    // Ring geometry
    localparam int STATE_WORDS  = 624;
    localparam int TWIST_OFFSET = 397;
    localparam int POS_W        = $clog2(STATE_WORDS);
    localparam int LAST_CELL    = STATE_WORDS - 1;

    // Operation codes
    localparam logic OP_GENERATE = 1'b0;
    localparam logic OP_RESEED   = 1'b1;

    // Recurrence and tempering constants
    localparam logic [31:0] TWIST_XOR = 32'h9908_b0df;
    localparam logic [31:0] TEMPER_B  = 32'h9d2c_5680;
    localparam logic [31:0] TEMPER_C  = 32'hefc6_0000;
    localparam logic [31:0] SEED_MULT = 32'd1812433253;
    localparam logic [31:0] HIGH_BIT  = 32'h8000_0000;
    localparam logic [31:0] LOW_BITS  = 32'h7fff_ffff;

    localparam logic [POS_W-1:0] SEED_LAST = POS_W'(STATE_WORDS - 1);

    // Seeder status handed to the top level
    typedef struct packed {
        logic        busy;
        logic [31:0] word;
    } seed_ctl_t;

endpackage

/* src/mtg_cell.sv */
`timescale 1ns / 1ps

module mtg_cell (
    input  logic        aclk,
    input  logic        shift_en,
    input  logic [31:0] word_in,
    output logic [31:0] word_out
);

    logic [31:0] word_reg;

    // Take the neighbor's word whenever the ring advances
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            word_reg <= word_in;
        end
    end

    assign word_out = word_reg;

endmodule

/* src/mtg_seeder.sv */
`timescale 1ns / 1ps

module mtg_seeder (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [31:0]             seed_value,
    output mtg_pkg::seed_ctl_t      ctl
);

    logic                      busy_reg, busy_next;
    logic [mtg_pkg::POS_W-1:0] count_reg, count_next;
    logic [31:0]               word_reg, word_next;
    logic [31:0]               mixed;
    logic [31:0]               product;
    logic [mtg_pkg::POS_W-1:0] index_next;

    // Next word of the seeding recurrence
    always_comb begin
        mixed      = word_reg ^ (word_reg >> 30);
        product    = mtg_pkg::SEED_MULT * mixed;
        index_next = count_reg + 1'b1;
    end

    // Walk the ring once, one word per cycle
    always_comb begin
        busy_next  = busy_reg;
        count_next = count_reg;
        word_next  = word_reg;
        if (start) begin
            busy_next  = 1'b1;
            count_next = '0;
            word_next  = seed_value;
        end else if (busy_reg) begin
            word_next  = product + {{(32 - mtg_pkg::POS_W){1'b0}}, index_next};
            count_next = index_next;
            if (count_reg == mtg_pkg::SEED_LAST) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign ctl.busy = busy_reg;
    assign ctl.word = word_reg;

endmodule

/* src/mtg_twist.sv */
`timescale 1ns / 1ps

module mtg_twist (
    input  logic [31:0] word_cur,
    input  logic [31:0] word_succ,
    input  logic [31:0] word_far,
    input  logic [5:0]  out_bits,
    output logic [31:0] word_new,
    output logic [31:0] word_result
);

    logic [31:0] y;
    logic [31:0] t0, t1, t2, t3;
    logic [31:0] keep_mask;

    // Twist one word, then temper it and keep the top bits
    always_comb begin
        y = (word_cur & mtg_pkg::HIGH_BIT) | (word_succ & mtg_pkg::LOW_BITS);
        word_new = word_far ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_XOR : 32'h0);
        t0 = word_new ^ (word_new >> 11);
        t1 = t0 ^ ((t0 << 7) & mtg_pkg::TEMPER_B);
        t2 = t1 ^ ((t1 << 15) & mtg_pkg::TEMPER_C);
        t3 = t2 ^ (t2 >> 18);
        // counts of 32 and above shift everything out and keep the whole word
        keep_mask   = ~(32'hffff_ffff >> out_bits);
        word_result = t3 & keep_mask;
    end

endmodule

/* src/mt19937_generator.sv */
`timescale 1ns / 1ps

// MT19937 generator built as a chain of 624 word cells that shifts by one on
// every generate item, so the current word, its successor and the word 397
// ahead always sit at fixed cells. One generate item can be accepted every
// cycle while no reseed is running and the output register is empty or being
// read; its word appears in the output register the cycle after acceptance.
// A reseed item gives no result and keeps the input not ready while the
// seeding multiplier shifts one word per cycle into the tail of the chain.
// Generating before the first reseed returns undefined words.

module mt19937_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [5:0]  s_out_bits,
    input  logic [31:0] s_seed_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_random_word
);

    logic [31:0] cell_q [mtg_pkg::STATE_WORDS];
    logic [31:0] tail_word;
    logic [31:0] twist_word;
    logic [31:0] result_word;
    logic        shift_en;
    logic        accept;
    logic        gen_fire;
    logic        seed_start;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_word_reg;
    mtg_pkg::seed_ctl_t seed_ctl;

    // Input handshake
    assign s_ready    = !seed_ctl.busy && (!m_valid_reg || m_ready);
    assign accept     = s_valid && s_ready;
    assign gen_fire   = accept && (s_operation == mtg_pkg::OP_GENERATE);
    assign seed_start = accept && (s_operation == mtg_pkg::OP_RESEED);

    mtg_seeder u_seeder (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (seed_start),
        .seed_value (s_seed_value),
        .ctl        (seed_ctl)
    );

    mtg_twist u_twist (
        .word_cur    (cell_q[0]),
        .word_succ   (cell_q[1]),
        .word_far    (cell_q[mtg_pkg::TWIST_OFFSET]),
        .out_bits    (s_out_bits),
        .word_new    (twist_word),
        .word_result (result_word)
    );

    // Advance the chain for each generated or seeded word
    assign shift_en  = gen_fire || seed_ctl.busy;
    assign tail_word = seed_ctl.busy ? seed_ctl.word : twist_word;

    for (genvar i = 0; i < mtg_pkg::STATE_WORDS; i++) begin : g_cells
        if (i == mtg_pkg::LAST_CELL) begin : g_tail
            mtg_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .word_in  (tail_word),
                .word_out (cell_q[i])
            );
        end else begin : g_body
            mtg_cell u_cell (
                .aclk     (aclk),
                .shift_en (shift_en),
                .word_in  (cell_q[i+1]),
                .word_out (cell_q[i])
            );
        end
    end

    // Output register: load on generate, drop once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (gen_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (gen_fire) begin
            m_word_reg <= result_word;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_random_word = m_word_reg;

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int ITEM_TARGET = 1950;
    localparam int DRAIN_LIMIT = 5000;

    typedef struct {
        logic        op;
        logic [5:0]  bits;
        logic [31:0] seed;
        bit          steady;
    } mt_request_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = mtg_pkg::OP_GENERATE;
    logic [5:0]  s_out_bits = 6'd0;
    logic [31:0] s_seed_value = 32'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_random_word;

    mt_request_t pending_requests[$];
    logic [31:0] expected_words[$];

    // Shadow of the generator state
    logic [31:0] ring_words [mtg_pkg::STATE_WORDS];
    int          ring_pos = mtg_pkg::STATE_WORDS - 1;

    bit steady_run = 1'b0;
    int error_count = 0;
    int words_checked = 0;
    int generates_seen = 0;
    int reseeds_seen = 0;

    mt19937_generator DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_out_bits    (s_out_bits),
        .s_seed_value  (s_seed_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_word (m_random_word)
    );

    always #1 aclk = ~aclk;

    // Fill the shadow ring from a seed word
    function automatic void seed_ring(logic [31:0] seed);
        logic [31:0] prev;
        ring_words[0] = seed;
        for (int i = 1; i < mtg_pkg::STATE_WORDS; i++) begin
            prev = ring_words[i - 1];
            ring_words[i] = mtg_pkg::SEED_MULT * (prev ^ (prev >> 30)) + 32'(i);
        end
        ring_pos = mtg_pkg::STATE_WORDS - 1;
    endfunction

    // Advance the position, twist one word and return it tempered
    function automatic logic [31:0] twist_next();
        int          nxt;
        int          far;
        logic [31:0] y;
        ring_pos = (ring_pos + 1) % mtg_pkg::STATE_WORDS;
        nxt = (ring_pos + 1) % mtg_pkg::STATE_WORDS;
        far = (ring_pos + mtg_pkg::TWIST_OFFSET) % mtg_pkg::STATE_WORDS;
        y = (ring_words[ring_pos] & mtg_pkg::HIGH_BIT) | (ring_words[nxt] & mtg_pkg::LOW_BITS);
        y = ring_words[far] ^ (y >> 1) ^ (y[0] ? mtg_pkg::TWIST_XOR : 32'h0);
        ring_words[ring_pos] = y;
        y ^= y >> 11;
        y ^= (y << 7) & mtg_pkg::TEMPER_B;
        y ^= (y << 15) & mtg_pkg::TEMPER_C;
        y ^= y >> 18;
        return y;
    endfunction

    // Mask that keeps the top n bits; counts above 32 keep the whole word
    function automatic logic [31:0] keep_top_bits(logic [5:0] n);
        if (n == 6'd0)
            return 32'h0;
        if (n >= 6'd32)
            return 32'hffff_ffff;
        return 32'hffff_ffff << (32 - n);
    endfunction

    task automatic add_request(logic op, logic [5:0] bits, logic [31:0] seed, bit steady);
        mt_request_t req;
        req.op = op;
        req.bits = bits;
        req.seed = seed;
        req.steady = steady;
        pending_requests.push_back(req);
    endtask

    // Driver: predict accepted items, then present the next one
    always @(posedge aclk) begin : driver
        mt_request_t req;
        bit          steady;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_operation == mtg_pkg::OP_RESEED) begin
                    seed_ring(s_seed_value);
                    reseeds_seen++;
                end else begin
                    expected_words.push_back(twist_next() & keep_top_bits(s_out_bits));
                    generates_seen++;
                end
            end
            if (!s_valid || s_ready) begin
                steady = pending_requests.size() != 0 && pending_requests[0].steady;
                steady_run <= steady;
                if (pending_requests.size() != 0 && (steady || $urandom_range(99) >= 11)) begin
                    req = pending_requests.pop_front();
                    s_valid <= 1'b1;
                    s_operation <= req.op;
                    s_out_bits <= req.bits;
                    s_seed_value <= req.seed;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted word with the oldest expectation
    always @(posedge aclk) begin : monitor
        logic [31:0] want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_words.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected word: expected none, actual %08h",
                             $time, m_random_word);
                end else begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (m_random_word !== want) begin
                        error_count++;
                        $display("%0t: random_word mismatch: expected %08h, actual %08h",
                                 $time, want, m_random_word);
                    end
                end
            end
            m_ready <= steady_run || ($urandom_range(99) >= 11);
        end
    end

    // Stimulus, reset and end of run
    initial begin : stimulus
        int run_len;
        int remaining;
        int waited;
        bit first_run;

        // Directed: bit-count extremes, seed extremes, back-to-back reseeds
        add_request(mtg_pkg::OP_RESEED, 6'd0, 32'h0000_0000, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd32, 32'h0000_0000, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd0, 32'h0000_0000, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd1, 32'h0000_0000, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd31, 32'h0000_0000, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd33, 32'h0000_0000, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd63, 32'hffff_ffff, 1'b0);
        add_request(mtg_pkg::OP_RESEED, 6'd63, 32'hffff_ffff, 1'b0);
        add_request(mtg_pkg::OP_RESEED, 6'd32, 32'd5489, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd32, 32'h0000_0000, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd32, 32'h1234_5678, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd16, 32'h0000_0000, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd2, 32'h0000_0000, 1'b0);
        add_request(mtg_pkg::OP_RESEED, 6'd0, 32'h8000_0000, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd32, 32'h5555_5555, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd0, 32'haaaa_aaaa, 1'b0);
        add_request(mtg_pkg::OP_RESEED, 6'd1, 32'h0000_0001, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd32, 32'h0000_0000, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd63, 32'h0000_0000, 1'b0);
        add_request(mtg_pkg::OP_GENERATE, 6'd1, 32'h0000_0000, 1'b0);

        // Random: reseed then a run of generates; the first long run never idles,
        // long runs can wrap the ring, empty runs give back-to-back reseeds
        first_run = 1'b1;
        while (pending_requests.size() < ITEM_TARGET) begin
            add_request(mtg_pkg::OP_RESEED, 6'($urandom_range(63)), $urandom, 1'b0);
            if (first_run)
                run_len = 700;
            else if ($urandom_range(7) == 0)
                run_len = $urandom_range(600, 900);
            else
                run_len = $urandom_range(0, 60);
            // Trim the last run so the total stays near the target
            remaining = ITEM_TARGET - pending_requests.size();
            if (run_len > remaining)
                run_len = remaining;
            for (int i = 0; i < run_len; i++)
                add_request(mtg_pkg::OP_GENERATE, 6'($urandom_range(63)), $urandom,
                            first_run);
            first_run = 1'b0;
        end

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Hold until every item has been accepted
        while (pending_requests.size() != 0 || s_valid)
            @(posedge aclk);

        // Drain the remaining words, bounded
        waited = 0;
        while (expected_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (20) @(posedge aclk);
        if (expected_words.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected words never arrived, oldest expected %08h",
                     $time, expected_words.size(), expected_words[0]);
        end

        $display("Run covered %0d reseeds and %0d generate items, %0d words compared",
                 reseeds_seen, generates_seen, words_checked);
        $display("Errors found: %0d", error_count);
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #2_000_000;
        $display("tb failed");
        $finish;
    end

endmodule
